// File: hdl/ral_pkg.sv
`default_nettype none
package ral_pkg;

	// fixed-point constants
	localparam logic signed [17:0] ROT_ONE = 18'sd65536;
	localparam logic signed [20:0] ROT_MAX = 21'sd131071;
	localparam logic signed [20:0] ROT_MIN = -21'sd131072;
	localparam logic [1:0] LAST_ROW = 2'd2;

	// last iteration index of the shared square root and divider
	localparam logic [4:0] SQRT_LAST = 5'd31;
	localparam logic [4:0] DIV_LAST = 5'd16;

	// one classified item as it waits in the queue
	typedef struct packed {
		logic signed [32:0] d;
		logic signed [32:0] v0;
		logic signed [32:0] v1;
		logic signed [32:0] v2;
		logic [63:0] vv;
		logic [63:0] prod;
		logic [31:0] t0;
		logic [31:0] t1;
		logic [31:0] t2;
		logic degen;
	} ral_job_t;

	// finished result of one item: matrix, translation, flag
	typedef struct packed {
		logic [8:0][17:0] rot;
		logic [2:0][31:0] shift;
		logic degen;
	} ral_bank_t;

	// skew term selection for one matrix entry
	typedef struct packed {
		logic used;
		logic neg;
		logic [1:0] idx;
	} ral_skew_t;

	localparam logic [8:0][17:0] ROT_IDENT = {
		18'd65536, 18'd0, 18'd0,
		18'd0, 18'd65536, 18'd0,
		18'd0, 18'd0, 18'd65536
	};

	// row and column of entry e, row-major
	localparam logic [1:0] ROW_OF [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
	localparam logic [1:0] COL_OF [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

	// signs of the cross-product matrix of the axis
	function automatic ral_skew_t skew_of(input logic [3:0] e);
		ral_skew_t s;
		s = '0;
		unique case (e)
			4'd1: s = '{used: 1'b1, neg: 1'b1, idx: 2'd2};
			4'd2: s = '{used: 1'b1, neg: 1'b0, idx: 2'd1};
			4'd3: s = '{used: 1'b1, neg: 1'b0, idx: 2'd2};
			4'd5: s = '{used: 1'b1, neg: 1'b1, idx: 2'd0};
			4'd6: s = '{used: 1'b1, neg: 1'b1, idx: 2'd1};
			4'd7: s = '{used: 1'b1, neg: 1'b0, idx: 2'd0};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// File: hdl/ral_front.sv
`default_nettype none
module ral_front (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  logic signed [31:0] point_a_x,
	input  logic signed [31:0] point_a_y,
	input  logic signed [31:0] point_a_z,
	input  logic signed [31:0] point_b_x,
	input  logic signed [31:0] point_b_y,
	input  logic signed [31:0] point_b_z,
	input  logic signed [15:0] normal_a_x,
	input  logic signed [15:0] normal_a_y,
	input  logic signed [15:0] normal_a_z,
	input  logic signed [15:0] normal_b_x,
	input  logic signed [15:0] normal_b_y,
	input  logic signed [15:0] normal_b_z,
	output logic job_valid,
	input  logic job_ready,
	output ral_pkg::ral_job_t job
);
	import ral_pkg::*;

	logic adv;
	logic v_s1, v_s2;
	logic signed [31:0] aa_x, aa_y, aa_z, bb_x, bb_y, bb_z, ab_x, ab_y, ab_z;
	logic signed [31:0] ayz, azy, azx, axz, axy, ayx;
	logic signed [33:0] na_c, nb_c, d_c, vx_c, vy_c, vz_c;
	logic [31:0] na_s1, nb_s1;
	logic signed [32:0] d_s1, vx_s1, vy_s1, vz_s1;
	logic [31:0] tx_s1, ty_s1, tz_s1;
	logic signed [65:0] sqx, sqy, sqz;
	logic [63:0] vv_c, prod_c;
	ral_job_t job_s2;

	function automatic logic [31:0] sat_sub(input logic signed [31:0] b,
		input logic signed [31:0] a);
		logic signed [32:0] diff;
		diff = 33'(b) - 33'(a);
		if (diff[32] != diff[31])
			return diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return diff[31:0];
	endfunction

	// both stages move together; stall only when the queue is full
	assign adv = !v_s2 || job_ready;
	assign req_ready = adv;

	// stage 1 products: squared norms, dot and cross product
	always_comb begin
		aa_x = normal_a_x * normal_a_x;
		aa_y = normal_a_y * normal_a_y;
		aa_z = normal_a_z * normal_a_z;
		bb_x = normal_b_x * normal_b_x;
		bb_y = normal_b_y * normal_b_y;
		bb_z = normal_b_z * normal_b_z;
		ab_x = normal_a_x * normal_b_x;
		ab_y = normal_a_y * normal_b_y;
		ab_z = normal_a_z * normal_b_z;
		ayz = normal_a_y * normal_b_z;
		azy = normal_a_z * normal_b_y;
		azx = normal_a_z * normal_b_x;
		axz = normal_a_x * normal_b_z;
		axy = normal_a_x * normal_b_y;
		ayx = normal_a_y * normal_b_x;
		na_c = 34'(aa_x) + 34'(aa_y) + 34'(aa_z);
		nb_c = 34'(bb_x) + 34'(bb_y) + 34'(bb_z);
		d_c = 34'(ab_x) + 34'(ab_y) + 34'(ab_z);
		vx_c = 34'(ayz) - 34'(azy);
		vy_c = 34'(azx) - 34'(axz);
		vz_c = 34'(axy) - 34'(ayx);
	end

	// stage 2 products: cross length squared and norm product
	always_comb begin
		sqx = vx_s1 * vx_s1;
		sqy = vy_s1 * vy_s1;
		sqz = vz_s1 * vz_s1;
		vv_c = sqx[63:0] + sqy[63:0] + sqz[63:0];
		prod_c = 64'(na_s1) * 64'(nb_s1);
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			na_s1 <= na_c[31:0];
			nb_s1 <= nb_c[31:0];
			d_s1 <= d_c[32:0];
			vx_s1 <= vx_c[32:0];
			vy_s1 <= vy_c[32:0];
			vz_s1 <= vz_c[32:0];
			tx_s1 <= sat_sub(point_b_x, point_a_x);
			ty_s1 <= sat_sub(point_b_y, point_a_y);
			tz_s1 <= sat_sub(point_b_z, point_a_z);
			job_s2.d <= d_s1;
			job_s2.v0 <= vx_s1;
			job_s2.v1 <= vy_s1;
			job_s2.v2 <= vz_s1;
			job_s2.vv <= vv_c;
			job_s2.prod <= prod_c;
			job_s2.t0 <= tx_s1;
			job_s2.t1 <= ty_s1;
			job_s2.t2 <= tz_s1;
			job_s2.degen <= (na_s1 == '0) || (nb_s1 == '0) || (vv_c == '0);
		end
	end

	assign job_valid = v_s2;
	assign job = job_s2;
endmodule
`default_nettype wire

// File: hdl/ral_fifo.sv
`default_nettype none
module ral_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ral_pkg::ral_job_t in_job,
	output logic out_valid,
	input  logic out_ready,
	output ral_pkg::ral_job_t out_job
);
	import ral_pkg::*;

	ral_job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_job = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= in_job;
	end
endmodule
`default_nettype wire

// File: hdl/ral_core.sv
`default_nettype none
module ral_core (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  ral_pkg::ral_job_t job,
	output logic bank_valid,
	input  logic bank_ready,
	output ral_pkg::ral_bank_t bank
);
	import ral_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SQRT, S_DIVL, S_DIVR, S_PRE, S_MAT, S_MFIN, S_DONE
	} state_t;

	localparam logic [2:0] DIV_COS = 3'd0;
	localparam logic [2:0] DIV_SIN = 3'd1;
	localparam logic [2:0] DIV_K0 = 3'd2;
	localparam logic [2:0] DIV_K1 = 3'd3;
	localparam logic [2:0] DIV_K2 = 3'd4;
	localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

	state_t state_q;
	logic sel_q, pv_q;
	logic [4:0] cnt_q;
	logic [2:0] didx_q;
	logic [3:0] eidx_q;
	ral_job_t job_q;
	logic [63:0] x_q, r_q, sbit_q;
	logic [31:0] p_q, l_q;
	logic [31:0] rem_q;
	logic [16:0] qs_q;
	logic neg_q;
	logic signed [17:0] c16_q;
	logic [16:0] s16_q;
	logic signed [17:0] k_q [3];
	logic signed [36:0] t_q [3];
	logic signed [17:0] sk_q [3];
	logic signed [54:0] prod_q;
	ral_bank_t bank_q;

	logic [63:0] sq_sum, x_n, r_n;
	logic sq_ge;
	logic [31:0] den;
	logic signed [33:0] num_s;
	logic [32:0] mag;
	logic [49:0] n_full;
	logic [32:0] rem2, rem_diff;
	logic dv_ge;
	logic [16:0] qs_n;
	logic signed [17:0] q_res;
	logic [1:0] kidx, pidx;
	logic signed [18:0] a1;
	logic signed [17:0] ent_c16, ent_sk;
	logic signed [20:0] ent_sum;
	logic [17:0] ent_sat;
	ral_skew_t sw;

	function automatic logic signed [17:0] round_shr16(input logic signed [35:0] x);
		logic [35:0] m;
		logic [35:0] q;
		m = x[35] ? 36'(-x) : 36'(x);
		q = (m + 36'd32768) >> 16;
		return x[35] ? -18'(q) : 18'(q);
	endfunction

	function automatic logic signed [20:0] round_shr32(input logic signed [54:0] x);
		logic [54:0] m;
		logic [54:0] q;
		m = x[54] ? 55'(-x) : 55'(x);
		q = (m + 55'h8000_0000) >> 32;
		return x[54] ? -21'(q) : 21'(q);
	endfunction

	// one step of the digit-by-digit square root
	always_comb begin
		sq_sum = r_q + sbit_q;
		sq_ge = x_q >= sq_sum;
		x_n = sq_ge ? x_q - sq_sum : x_q;
		r_n = sq_ge ? (r_q >> 1) + sbit_q : r_q >> 1;
	end

	// divider operand set-up and one restoring step
	always_comb begin
		den = (didx_q == DIV_COS || didx_q == DIV_SIN) ? p_q : l_q;
		unique case (didx_q)
			DIV_COS: num_s = 34'(job_q.d);
			DIV_SIN: num_s = $signed({2'b00, l_q});
			DIV_K0: num_s = 34'(job_q.v0);
			DIV_K1: num_s = 34'(job_q.v1);
			default: num_s = 34'(job_q.v2);
		endcase
		mag = num_s[33] ? 33'(-num_s) : 33'(num_s);
		n_full = {1'b0, mag, 16'h0000} + 50'(den[31:1]);
		rem2 = {rem_q, qs_q[16]};
		rem_diff = rem2 - {1'b0, den};
		dv_ge = rem2 >= {1'b0, den};
		qs_n = {qs_q[15:0], dv_ge};
		q_res = neg_q ? -18'(qs_n) : 18'(qs_n);
		kidx = 2'(didx_q - DIV_K0);
	end

	// matrix entry assembly
	always_comb begin
		pidx = cnt_q[1:0];
		a1 = 19'sd65536 - 19'(c16_q);
		sw = skew_of(eidx_q);
		ent_c16 = (ROW_OF[eidx_q] == COL_OF[eidx_q]) ? c16_q : 18'sd0;
		ent_sk = !sw.used ? 18'sd0 : (sw.neg ? -sk_q[sw.idx] : sk_q[sw.idx]);
		ent_sum = round_shr32(prod_q) + 21'(ent_c16) + 21'(ent_sk);
		if (ent_sum > ROT_MAX)
			ent_sat = ROT_MAX[17:0];
		else if (ent_sum < ROT_MIN)
			ent_sat = ROT_MIN[17:0];
		else
			ent_sat = ent_sum[17:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			sel_q <= 1'b0;
			didx_q <= DIV_COS;
			pv_q <= 1'b0;
		end else begin
			pv_q <= state_q == S_MAT;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					sel_q <= 1'b0;
					if (job_valid)
						state_q <= job.degen ? S_DONE : S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == SQRT_LAST) begin
						cnt_q <= '0;
						sel_q <= 1'b1;
						if (sel_q) begin
							didx_q <= DIV_COS;
							state_q <= S_DIVL;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_DIVL: begin
					cnt_q <= '0;
					state_q <= S_DIVR;
				end
				S_DIVR: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q <= '0;
						if (didx_q == DIV_K2) begin
							state_q <= S_PRE;
						end else begin
							didx_q <= didx_q + 3'd1;
							state_q <= S_DIVL;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_PRE: begin
					if (cnt_q == 5'd2) begin
						cnt_q <= '0;
						state_q <= S_MAT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_MAT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd8)
						state_q <= S_MFIN;
				end
				S_MFIN: state_q <= S_DONE;
				S_DONE: begin
					if (bank_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					job_q <= job;
					bank_q.shift <= {job.t2, job.t1, job.t0};
					bank_q.degen <= job.degen;
					bank_q.rot <= ROT_IDENT;
					x_q <= job.prod;
					r_q <= '0;
					sbit_q <= SQRT_BIT0;
				end
			end
			S_SQRT: begin
				if (cnt_q == SQRT_LAST && !sel_q) begin
					// first root done, start on the cross length
					p_q <= r_n[31:0];
					x_q <= job_q.vv;
					r_q <= '0;
					sbit_q <= SQRT_BIT0;
				end else begin
					x_q <= x_n;
					r_q <= r_n;
					sbit_q <= sbit_q >> 2;
					if (cnt_q == SQRT_LAST)
						l_q <= r_n[31:0];
				end
			end
			S_DIVL: begin
				rem_q <= n_full[48:17];
				qs_q <= n_full[16:0];
				neg_q <= num_s[33];
			end
			S_DIVR: begin
				rem_q <= dv_ge ? rem_diff[31:0] : rem2[31:0];
				qs_q <= qs_n;
				if (cnt_q == DIV_LAST) begin
					if (didx_q == DIV_COS)
						c16_q <= q_res;
					else if (didx_q == DIV_SIN)
						s16_q <= qs_n;
					else
						k_q[kidx] <= q_res;
				end
			end
			S_PRE: begin
				t_q[pidx] <= a1 * k_q[pidx];
				sk_q[pidx] <= round_shr16($signed({1'b0, s16_q}) * k_q[pidx]);
			end
			S_MAT: begin
				prod_q <= t_q[ROW_OF[cnt_q[3:0]]] * k_q[COL_OF[cnt_q[3:0]]];
				eidx_q <= cnt_q[3:0];
			end
			default: ;
		endcase
		if (pv_q)
			bank_q.rot[8 - eidx_q] <= ent_sat;
	end

	assign job_ready = state_q == S_IDLE;
	assign bank_valid = state_q == S_DONE;
	assign bank = bank_q;
endmodule
`default_nettype wire

// File: hdl/ral_emit.sv
`default_nettype none
module ral_emit (
	input  logic clk,
	input  logic arst_n,
	input  logic bank_valid,
	output logic bank_ready,
	input  ral_pkg::ral_bank_t bank,
	output logic res_valid,
	input  logic res_ready,
	output logic [1:0] row_index,
	output logic signed [17:0] rot_col0,
	output logic signed [17:0] rot_col1,
	output logic signed [17:0] rot_col2,
	output logic signed [31:0] shift_component,
	output logic last_row,
	output logic degenerate
);
	import ral_pkg::*;

	ral_bank_t bank_q;
	logic full_q;
	logic [1:0] row_q;
	logic take, load;

	assign take = full_q && res_ready;
	assign bank_ready = !full_q || (take && row_q == LAST_ROW);
	assign load = bank_valid && bank_ready;

	// row sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			row_q <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			row_q <= '0;
		end else if (take) begin
			if (row_q == LAST_ROW)
				full_q <= 1'b0;
			else
				row_q <= row_q + 2'd1;
		end
	end

	// result bank held while rows drain
	always_ff @(posedge clk) begin
		if (load)
			bank_q <= bank;
	end

	// row select; rot is packed with entry 0 at the top
	always_comb begin
		case (row_q)
			2'd0: begin
				rot_col0 = $signed(bank_q.rot[8]);
				rot_col1 = $signed(bank_q.rot[7]);
				rot_col2 = $signed(bank_q.rot[6]);
				shift_component = $signed(bank_q.shift[0]);
			end
			2'd1: begin
				rot_col0 = $signed(bank_q.rot[5]);
				rot_col1 = $signed(bank_q.rot[4]);
				rot_col2 = $signed(bank_q.rot[3]);
				shift_component = $signed(bank_q.shift[1]);
			end
			default: begin
				rot_col0 = $signed(bank_q.rot[2]);
				rot_col1 = $signed(bank_q.rot[1]);
				rot_col2 = $signed(bank_q.rot[0]);
				shift_component = $signed(bank_q.shift[2]);
			end
		endcase
	end

	assign res_valid = full_q;
	assign row_index = row_q;
	assign last_row = row_q == LAST_ROW;
	assign degenerate = bank_q.degen;
endmodule
`default_nettype wire

// File: hdl/rigid_align_from_point_normals_top.sv
// Rigid alignment from two points and two normals. Each item gives three results, one per
// row, with row r of the Rodrigues rotation turning normal A onto normal B (Q1.16) and the
// saturated translation B-A component r (Q16.16). A zero normal or parallel normals set
// degenerate and give the identity. The front takes an item per cycle into a two-entry
// queue while it has room; the back unit runs a non-degenerate item through two 32-step
// square roots and five restoring divisions on one shared iterative datapath, then nine
// matrix entries, and skips them for a degenerate one. The three rows leave back to back
// from an output bank, stalls apart; the back unit works on the next item as they drain.
`default_nettype none
module rigid_align_from_point_normals_top (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  logic signed [31:0] point_a_x,
	input  logic signed [31:0] point_a_y,
	input  logic signed [31:0] point_a_z,
	input  logic signed [31:0] point_b_x,
	input  logic signed [31:0] point_b_y,
	input  logic signed [31:0] point_b_z,
	input  logic signed [15:0] normal_a_x,
	input  logic signed [15:0] normal_a_y,
	input  logic signed [15:0] normal_a_z,
	input  logic signed [15:0] normal_b_x,
	input  logic signed [15:0] normal_b_y,
	input  logic signed [15:0] normal_b_z,
	output logic res_valid,
	input  logic res_ready,
	output logic [1:0] row_index,
	output logic signed [17:0] rot_col0,
	output logic signed [17:0] rot_col1,
	output logic signed [17:0] rot_col2,
	output logic signed [31:0] shift_component,
	output logic last_row,
	output logic degenerate
);
	import ral_pkg::*;

	logic f_valid, f_ready, q_valid, q_ready, b_valid, b_ready;
	ral_job_t f_job, q_job;
	ral_bank_t b_bank;

	// classify items
	ral_front u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.point_a_x(point_a_x), .point_a_y(point_a_y), .point_a_z(point_a_z),
		.point_b_x(point_b_x), .point_b_y(point_b_y), .point_b_z(point_b_z),
		.normal_a_x(normal_a_x), .normal_a_y(normal_a_y), .normal_a_z(normal_a_z),
		.normal_b_x(normal_b_x), .normal_b_y(normal_b_y), .normal_b_z(normal_b_z),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	// queue between front and back
	ral_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
		.out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
	);

	// rotation solver
	ral_core u_core (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.bank_valid(b_valid), .bank_ready(b_ready), .bank(b_bank)
	);

	// row output
	ral_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.bank_valid(b_valid), .bank_ready(b_ready), .bank(b_bank),
		.res_valid(res_valid), .res_ready(res_ready), .row_index(row_index),
		.rot_col0(rot_col0), .rot_col1(rot_col1), .rot_col2(rot_col2),
		.shift_component(shift_component), .last_row(last_row),
		.degenerate(degenerate)
	);
endmodule
`default_nettype wire

// File: hdl/ral_checker.sv
`default_nettype none
module ral_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic [1:0] row_index,
	input logic signed [17:0] rot_col0,
	input logic signed [17:0] rot_col1,
	input logic signed [17:0] rot_col2,
	input logic last_row,
	input logic degenerate
);
	import ral_pkg::*;

	// a stalled row holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(row_index))
		else $error("stalled row changed");

	// last flag marks the third row only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (last_row == (row_index == LAST_ROW)) && row_index != 2'd3)
		else $error("bad row index or last flag");

	// rows of one item follow back to back
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && row_index != LAST_ROW |=>
		res_valid && row_index == $past(row_index) + 2'd1)
		else $error("row sequence broken");

	// the first row of a degenerate item carries the identity
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && degenerate && row_index == 2'd0 |->
		rot_col0 == ROT_ONE && rot_col1 == 18'sd0 && rot_col2 == 18'sd0)
		else $error("degenerate row not identity");
endmodule

bind rigid_align_from_point_normals_top ral_checker u_chk (
	.clk(clk), .arst_n(arst_n), .res_valid(res_valid), .res_ready(res_ready),
	.row_index(row_index), .rot_col0(rot_col0), .rot_col1(rot_col1),
	.rot_col2(rot_col2), .last_row(last_row), .degenerate(degenerate)
);
`default_nettype wire

// File: sim/rigid_align_from_point_normals_top_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module rigid_align_from_point_normals_top_tb;
	import ral_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 200;

	// one input item: two points and two normals
	typedef struct {
		logic signed [31:0] pa [3];
		logic signed [31:0] pb [3];
		logic signed [15:0] na [3];
		logic signed [15:0] nb [3];
	} pose_pair_t;

	// one row of the expected result
	typedef struct {
		logic [1:0] row;
		logic signed [17:0] rot [3];
		logic signed [31:0] shift;
		logic last;
		logic degen;
	} row_result_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic signed [31:0] point_a_x, point_a_y, point_a_z;
	logic signed [31:0] point_b_x, point_b_y, point_b_z;
	logic signed [15:0] normal_a_x, normal_a_y, normal_a_z;
	logic signed [15:0] normal_b_x, normal_b_y, normal_b_z;
	logic res_valid;
	logic res_ready;
	logic [1:0] row_index;
	logic signed [17:0] rot_col0, rot_col1, rot_col2;
	logic signed [31:0] shift_component;
	logic last_row;
	logic degenerate;

	row_result_t expected_rows [$];
	int errors;
	int idle_cycles;
	bit hold_request;
	bit send_gaps;
	bit recv_gaps;

	rigid_align_from_point_normals_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.point_a_x(point_a_x), .point_a_y(point_a_y), .point_a_z(point_a_z),
		.point_b_x(point_b_x), .point_b_y(point_b_y), .point_b_z(point_b_z),
		.normal_a_x(normal_a_x), .normal_a_y(normal_a_y), .normal_a_z(normal_a_z),
		.normal_b_x(normal_b_x), .normal_b_y(normal_b_y), .normal_b_z(normal_b_z),
		.res_valid(res_valid), .res_ready(res_ready),
		.row_index(row_index), .rot_col0(rot_col0), .rot_col1(rot_col1),
		.rot_col2(rot_col2), .shift_component(shift_component),
		.last_row(last_row), .degenerate(degenerate)
	);

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x = x - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	// num / den rounded to nearest, ties away from zero
	function automatic longint div_nearest(input longint num, input longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	// num / 2^sh rounded to nearest, ties away from zero
	function automatic longint shift_nearest(input longint num, input int sh);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (mag + (64'd1 << (sh - 1))) >> sh;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// rotation rows and translation for one item
	function automatic void align_rows(input pose_pair_t it, output row_result_t rows [3]);
		longint a [3];
		longint b [3];
		longint v [3];
		longint k [3];
		longint sk [3];
		longint rm [3][3];
		longint unsigned na, nb, vv, p, len;
		longint d, c16, s16, a1;
		bit degen;
		for (int i = 0; i < 3; i++) begin
			a[i] = it.na[i];
			b[i] = it.nb[i];
		end
		na = 0;
		nb = 0;
		vv = 0;
		d = 0;
		for (int i = 0; i < 3; i++) begin
			na += longint'(a[i] * a[i]);
			nb += longint'(b[i] * b[i]);
			d += a[i] * b[i];
		end
		v[0] = a[1] * b[2] - a[2] * b[1];
		v[1] = a[2] * b[0] - a[0] * b[2];
		v[2] = a[0] * b[1] - a[1] * b[0];
		for (int i = 0; i < 3; i++)
			vv += longint'(v[i] * v[i]);
		for (int r = 0; r < 3; r++)
			for (int q = 0; q < 3; q++)
				rm[r][q] = (r == q) ? 65536 : 0;
		degen = (na == 0) || (nb == 0) || (vv == 0);
		if (!degen) begin
			p = int_sqrt(na * nb);
			len = int_sqrt(vv);
			c16 = clip(div_nearest(d * 65536, p), -65536, 65536);
			s16 = clip(div_nearest(longint'(len) * 65536, p), 0, 65536);
			a1 = 65536 - c16;
			for (int i = 0; i < 3; i++) begin
				k[i] = div_nearest(v[i] * 65536, len);
				sk[i] = shift_nearest(s16 * k[i], 16);
			end
			for (int r = 0; r < 3; r++)
				for (int q = 0; q < 3; q++)
					rm[r][q] = shift_nearest(a1 * k[r] * k[q], 32) + ((r == q) ? c16 : 0);
			rm[0][1] -= sk[2];
			rm[0][2] += sk[1];
			rm[1][0] += sk[2];
			rm[1][2] -= sk[0];
			rm[2][0] -= sk[1];
			rm[2][1] += sk[0];
		end
		for (int r = 0; r < 3; r++) begin
			rows[r].row = r[1:0];
			for (int q = 0; q < 3; q++)
				rows[r].rot[q] = 18'(clip(rm[r][q], -131072, 131071));
			rows[r].shift = 32'(clip(longint'(it.pb[r]) - longint'(it.pa[r]),
				-64'sd2147483648, 64'sd2147483647));
			rows[r].last = (r == 2);
			rows[r].degen = degen;
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// offer one item and wait for it to be taken
	task automatic send_item(input pose_pair_t it);
		row_result_t rows [3];
		int gap;
		gap = send_gaps ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		align_rows(it, rows);
		{point_a_x, point_a_y, point_a_z} = {it.pa[0], it.pa[1], it.pa[2]};
		{point_b_x, point_b_y, point_b_z} = {it.pb[0], it.pb[1], it.pb[2]};
		{normal_a_x, normal_a_y, normal_a_z} = {it.na[0], it.na[1], it.na[2]};
		{normal_b_x, normal_b_y, normal_b_z} = {it.nb[0], it.nb[1], it.nb[2]};
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		for (int r = 0; r < 3; r++)
			expected_rows.push_back(rows[r]);
		@(negedge clk);
	endtask

	function automatic pose_pair_t make_item(input int ax, ay, az, bx, by, bz);
		pose_pair_t it;
		for (int i = 0; i < 3; i++) begin
			it.pa[i] = $urandom;
			it.pb[i] = $urandom;
		end
		it.na = '{16'(ax), 16'(ay), 16'(az)};
		it.nb = '{16'(bx), 16'(by), 16'(bz)};
		return it;
	endfunction

	// zero normals and parallel normals in both senses
	task automatic test_degenerate();
		send_item(make_item(0, 0, 0, 16384, 0, 0));
		send_item(make_item(0, 16384, 0, 0, 0, 0));
		send_item(make_item(0, 0, 0, 0, 0, 0));
		send_item(make_item(100, 200, -300, 200, 400, -600));
		send_item(make_item(16384, 0, 0, -16384, 0, 0));
		send_item(make_item(-32768, -32768, -32768, 32767 - 32767, 0, 0));
		send_item(make_item(5, -7, 3, -10, 14, -6));
	endtask

	// extreme normals, near-parallel cosine clamp, saturating translation
	task automatic test_extremes();
		pose_pair_t it;
		send_item(make_item(16384, 0, 0, 0, 16384, 0));
		send_item(make_item(0, 0, 16384, 0, 16384, 0));
		send_item(make_item(-32768, -32768, -32768, 32767, 32767, -32768));
		send_item(make_item(32767, 32767, 32767, 32767, 32767, 32766));
		send_item(make_item(-32768, 0, 0, 32767, 1, 0));
		send_item(make_item(1, 0, 0, 0, 1, 0));
		send_item(make_item(1, 1, 0, 1, 0, 1));
		send_item(make_item(32767, -32768, 1, -1, 32767, -32768));
		send_item(make_item(12000, -9000, 300, -11999, 9001, -299));
		it = make_item(16384, 16384, 0, 0, 16384, 16384);
		it.pa = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000};
		it.pb = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
		send_item(it);
		it.pa = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
		it.pb = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000};
		send_item(it);
	endtask

	// receiver holds off while the sender keeps offering items
	task automatic test_backpressure();
		hold_request = 1'b1;
		send_gaps = 1'b0;
		repeat (8)
			send_item(make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
		send_gaps = 1'b1;
	endtask

	// mostly well-formed random normals, some degenerate ones mixed in
	task automatic test_random(input int count);
		pose_pair_t it;
		int sel, s;
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0) begin
				send_gaps = ($urandom_range(0, 3) != 0);
				recv_gaps = ($urandom_range(0, 3) != 0);
			end
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else if (sel < 8) begin
				it = make_item($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
					$urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
					$urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
			end else if (sel == 8) begin
				it = make_item($urandom, $urandom, $urandom, 0, 0, 0);
				s = $urandom_range(1, 3);
				it.na = '{16'(it.na[0] >>> 2), 16'(it.na[1] >>> 2), 16'(it.na[2] >>> 2)};
				it.nb = '{16'(it.na[0] * s), 16'(it.na[1] * s), 16'(it.na[2] * s)};
				if ($urandom_range(0, 1))
					it.nb = '{-it.nb[0], -it.nb[1], -it.nb[2]};
			end else begin
				it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				it.na[$urandom_range(0, 2)] = 16'sd0;
				if ($urandom_range(0, 1))
					it.nb = '{16'sd0, 16'sd0, 16'sd0};
			end
			send_item(it);
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// result side readiness
	initial begin
		int stall;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				stall = recv_gaps ? $urandom_range(0, 16) : 0;
				if (stall > 0) begin
					res_ready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			res_ready = 1'b1;
			do
				@(posedge clk);
			while (!res_valid);
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		row_result_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_rows.size() == 0) begin
					$display("unexpected result row %0d", row_index);
					errors++;
				end else begin
					want = expected_rows.pop_front();
					if (row_index != want.row)
						report_mismatch("row_index", row_index, want.row);
					if (rot_col0 != want.rot[0])
						report_mismatch("rot_col0", rot_col0, want.rot[0]);
					if (rot_col1 != want.rot[1])
						report_mismatch("rot_col1", rot_col1, want.rot[1]);
					if (rot_col2 != want.rot[2])
						report_mismatch("rot_col2", rot_col2, want.rot[2]);
					if (shift_component != want.shift)
						report_mismatch("shift_component", shift_component, want.shift);
					if (last_row != want.last)
						report_mismatch("last_row", last_row, want.last);
					if (degenerate != want.degen)
						report_mismatch("degenerate", degenerate, want.degen);
				end
			end
			if ((res_valid && res_ready) || (req_valid && req_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout with %0d rows outstanding", expected_rows.size());
				$display("rigid_align_from_point_normals_top_tb failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// test sequence
	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_request = 1'b0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		arst_n = 1'b0;
		req_valid = 1'b0;
		{point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z} = '0;
		{normal_a_x, normal_a_y, normal_a_z, normal_b_x, normal_b_y, normal_b_z} = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_degenerate();
		test_extremes();
		test_backpressure();
		test_random(140);
		req_valid = 1'b0;
		while (expected_rows.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("rigid_align_from_point_normals_top_tb passed");
		end else begin
			$display("rigid_align_from_point_normals_top_tb failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
